// File: hdl/bbs_pkg.sv
// ============================================================================
// bbs_pkg
// Shared widths, reset values and codes for the BBS key byte generator.
// ============================================================================
`default_nettype none

package bbs_pkg;

  // Running value and modulus width
  localparam int unsigned DATA_W = 32;
  // Prime factor register width
  localparam int unsigned FACTOR_W = 16;
  // Bits packed into one key byte
  localparam int unsigned BITS_PER_BYTE = 8;
  // Default number of bytes in one key
  localparam int unsigned KEY_BYTES_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Q = 2'd1;

  localparam logic [FACTOR_W-1:0] FACTOR_P_RESET = 16'd5651;
  localparam logic [FACTOR_W-1:0] FACTOR_Q_RESET = 16'd5623;

  // Input word kinds (carried on tuser)
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

endpackage : bbs_pkg

`default_nettype wire

// File: hdl/bbs_key_byte_generator.sv
// Operation: a generate word runs eight dependent squarings in the bit-serial
//   unit, with an extra reduction when the running value is not below the
//   modulus at the first step, then the byte is registered on the output; no new
//   input word is taken until the byte has moved to the output register.
//   A load word sets the running value and clears the byte position.
// Reset: asynchronous active low; factors return to 5651 and 5623, the running
//   value and byte position clear, and no output word is pending.
// ============================================================================
// bbs_key_byte_generator
// Blum Blum Shub key byte generator with a stream input, a stream output
// and a register write port for the two modulus factors.
// ============================================================================
`default_nettype none

module bbs_key_byte_generator #(
  parameter int unsigned KEY_BYTES = bbs_pkg::KEY_BYTES_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [bbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [bbs_pkg::FACTOR_W-1:0]  cfg_data_i,
  // Input stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [31:0]                   s_axis_tdata,  // [31:0] seed
  input  wire                          s_axis_tuser,  // [0] cmd
  // Output stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] key_byte
  output logic                         m_axis_tlast   // last_of_key
);

  import bbs_pkg::*;

  localparam int unsigned PosW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned BitW = $clog2(BITS_PER_BYTE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIN
  } state_e;

  state_e                   state_q;
  logic [FACTOR_W-1:0]      factor_p_q;
  logic [FACTOR_W-1:0]      factor_q_q;
  logic [DATA_W-1:0]        x_q;
  logic [PosW-1:0]          pos_q;
  logic [BitW-1:0]          bit_cnt_q;
  logic [BITS_PER_BYTE-1:0] byte_q;
  logic                     start_q;
  logic                     out_valid_q;
  logic [7:0]               out_data_q;
  logic                     out_last_q;

  logic [DATA_W-1:0]        modulus;
  logic                     sqr_done;
  logic [DATA_W-1:0]        sqr_x;
  logic                     in_fire;
  logic                     pos_last;

  assign modulus     = {{(DATA_W-FACTOR_W){1'b0}}, factor_p_q} *
                       {{(DATA_W-FACTOR_W){1'b0}}, factor_q_q};
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign pos_last    = (pos_q == PosW'(KEY_BYTES - 1));
  assign cfg_ready_o = 1'b1;

  // Modulus factor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_p_q <= FACTOR_P_RESET;
      factor_q_q <= FACTOR_Q_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FACTOR_P: factor_p_q <= cfg_data_i;
        REG_FACTOR_Q: factor_q_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Squaring unit
  bbs_sqr u_sqr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (x_q),
    .m_i     (modulus),
    .done_o  (sqr_done),
    .x_o     (sqr_x)
  );

  // Step sequencer, running value, byte assembly and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      pos_q       <= '0;
      bit_cnt_q   <= '0;
      byte_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Kick a squaring on a generate word and after every step but the last
      start_q <= ((state_q == ST_IDLE) && in_fire && (s_axis_tuser == CMD_GEN)) ||
                 ((state_q == ST_STEP) && sqr_done &&
                  (bit_cnt_q != BitW'(BITS_PER_BYTE - 1)));
      if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == CMD_LOAD) begin
              x_q   <= s_axis_tdata;
              pos_q <= '0;
            end else begin
              bit_cnt_q <= '0;
              state_q   <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          if (sqr_done) begin
            x_q       <= sqr_x;
            byte_q    <= {sqr_x[0], byte_q[BITS_PER_BYTE-1:1]};
            bit_cnt_q <= bit_cnt_q + 1'b1;
            if (bit_cnt_q == BitW'(BITS_PER_BYTE - 1)) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          // Hold the byte until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= byte_q;
            out_last_q  <= pos_last;
            pos_q       <= pos_last ? '0 : pos_q + 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // Squaring results only arrive while a byte is being built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqr_done |-> (state_q == ST_STEP))
    else $error("squaring result outside a byte step");

  // A new output word is only loaded from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_FIN))
    else $error("output word loaded outside finish");

  // Byte position stays inside the key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(KEY_BYTES - 1))
    else $error("byte position beyond key length");

  // The last byte of a key restarts the byte position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_FIN && state_q == ST_IDLE && out_last_q) |-> (pos_q == '0))
    else $error("byte position not wrapped after last byte");
`endif

endmodule : bbs_key_byte_generator

`default_nettype wire

// File: hdl/bbs_sqr.sv
// ============================================================================
// bbs_sqr
// One modular squaring x = x*x mod m, bit-serial: an optional restoring
// reduction when x is not below m, then an MSB-first shift-add-reduce
// multiply. A zero modulus keeps the low word of x*x.
// ============================================================================
`default_nettype none

module bbs_sqr (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire [bbs_pkg::DATA_W-1:0] x_i,
  input  wire [bbs_pkg::DATA_W-1:0] m_i,
  output logic                      done_o,
  output logic [bbs_pkg::DATA_W-1:0] x_o
);

  import bbs_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_RED,
    S_MUL
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     cnt_q;
  logic [DATA_W-1:0]   a_q;     // multiplicand
  logic [DATA_W-1:0]   mpl_q;   // bits shifted out MSB first
  logic [DATA_W-1:0]   r_q;     // partial remainder / result
  logic [DATA_W-1:0]   m_q;
  logic                m_zero_q;
  logic                done_q;

  logic [DATA_W:0]     red_t;
  logic [DATA_W-1:0]   red_res;
  logic [DATA_W-1:0]   addend;
  logic [DATA_W+1:0]   s0;
  logic [DATA_W+1:0]   m1;
  logic [DATA_W+1:0]   m2;
  logic [DATA_W+1:0]   s1;
  logic [DATA_W+1:0]   s2;
  logic [DATA_W-1:0]   mul_res;
  logic                last_cnt;

  assign last_cnt = (cnt_q == CntW'(DATA_W - 1));

  // Reduction digit: shift in one bit of x, subtract m once if reached
  always_comb begin
    red_t = {r_q, mpl_q[DATA_W-1]};
    if (red_t >= {1'b0, m_q}) begin
      red_res = DATA_W'(red_t - {1'b0, m_q});
    end else begin
      red_res = red_t[DATA_W-1:0];
    end
  end

  // Multiply digit: r = 2r + bit*a, then pick the candidate below m
  always_comb begin
    addend  = mpl_q[DATA_W-1] ? a_q : '0;
    s0      = {1'b0, r_q, 1'b0} + {2'b00, addend};
    m1      = {2'b00, m_q};
    m2      = {1'b0, m_q, 1'b0};
    s1      = s0 - m1;
    s2      = s0 - m2;
    if (m_zero_q) begin
      mul_res = s0[DATA_W-1:0];
    end else if (s0 >= m2) begin
      mul_res = s2[DATA_W-1:0];
    end else if (s0 >= m1) begin
      mul_res = s1[DATA_W-1:0];
    end else begin
      mul_res = s0[DATA_W-1:0];
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      m_zero_q <= 1'b0;
      a_q      <= '0;
      mpl_q    <= '0;
      r_q      <= '0;
      m_q      <= '0;
    end else begin
      done_q <= (state_q == S_MUL) && last_cnt;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            a_q      <= x_i;
            mpl_q    <= x_i;
            r_q      <= '0;
            m_q      <= m_i;
            m_zero_q <= (m_i == '0);
            cnt_q    <= '0;
            state_q  <= S_CHK;
          end
        end
        S_CHK: begin
          if (!m_zero_q && (a_q >= m_q)) begin
            state_q <= S_RED;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_RED: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_cnt) begin
            a_q     <= red_res;
            mpl_q   <= red_res;
            r_q     <= '0;
            state_q <= S_MUL;
          end else begin
            mpl_q <= mpl_q << 1;
            r_q   <= red_res;
          end
        end
        S_MUL: begin
          mpl_q <= mpl_q << 1;
          r_q   <= mul_res;
          cnt_q <= cnt_q + 1'b1;
          if (last_cnt) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign x_o    = r_q;

endmodule : bbs_sqr

`default_nettype wire
